@@ design/bjq_pkg.sv @@
// ----------------------------------------------------------------------------
// bjq_pkg
// Shared types, codes and defaults for the bounded job queue.
// ----------------------------------------------------------------------------
package bjq_pkg;

  // Default sizing
  localparam int unsigned DEPTH_DEF        = 16;
  localparam int unsigned JOB_WIDTH_DEF    = 64;
  localparam int unsigned ACTIVE_WIDTH_DEF = 8;

  // Fixed field widths of the transactions
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned JOB_W    = 64;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned QCNT_W   = 5;
  localparam int unsigned ACNT_W   = 8;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned POL_W    = 2;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned CFG_A_W  = 1;

  // Request types
  localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DONE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLOSE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
  localparam logic [STATUS_W-1:0] ST_DROP_OLDEST = 4'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_FULL_RETRY  = 4'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY_RETRY = 4'd4;
  localparam logic [STATUS_W-1:0] ST_CLOSED      = 4'd5;
  localparam logic [STATUS_W-1:0] ST_PUSH_CLOSED = 4'd6;
  localparam logic [STATUS_W-1:0] ST_CANCELLED   = 4'd7;
  localparam logic [STATUS_W-1:0] ST_NOTHING     = 4'd8;

  // Full policies
  localparam logic [POL_W-1:0] POL_BLOCK       = 2'd0;
  localparam logic [POL_W-1:0] POL_DROP_NEWEST = 2'd1;
  localparam logic [POL_W-1:0] POL_DROP_OLDEST = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_CAPACITY = 1'd0;
  localparam logic [CFG_A_W-1:0] CFG_POLICY   = 1'd1;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [JOB_W-1:0] job_data;
  } bjq_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [JOB_W-1:0]    job_out;
    logic                last;
    logic [QCNT_W-1:0]   queue_count;
    logic [ACNT_W-1:0]   active_count;
    logic                drained;
    logic                is_closed;
  } bjq_rsp_t;

  // Per-cycle control of the cell row
  typedef struct packed {
    logic shift;  // every cell takes its upper neighbor, cell 0 drops out
    logic wr_en;  // one cell loads the incoming job
  } bjq_chain_ctrl_t;

endpackage

@@ design/bjq_cell.sv @@
// ----------------------------------------------------------------------------
// bjq_cell
// One queue slot: loads a new job or takes the job of its upper neighbor.
// ----------------------------------------------------------------------------
module bjq_cell #(
  parameter int unsigned JOB_WIDTH = bjq_pkg::JOB_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  logic                 wr_i,
  input  logic [JOB_WIDTH-1:0] wr_data_i,
  input  logic [JOB_WIDTH-1:0] nbr_data_i,
  output logic [JOB_WIDTH-1:0] data_o
);

  logic [JOB_WIDTH-1:0] data_q;
  logic [JOB_WIDTH-1:0] data_d;

  // A write wins over the shift: on a drop-oldest push the new tail slot
  // is the one just vacated by the shift.
  always_comb begin
    data_d = data_q;
    if (wr_i) begin
      data_d = wr_data_i;
    end else if (shift_i) begin
      data_d = nbr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

@@ design/bjq_chain.sv @@
// ----------------------------------------------------------------------------
// bjq_chain
// Row of DEPTH cells; cell 0 is the queue head, jobs move toward it.
// ----------------------------------------------------------------------------
module bjq_chain #(
  parameter int unsigned DEPTH     = bjq_pkg::DEPTH_DEF,
  parameter int unsigned JOB_WIDTH = bjq_pkg::JOB_WIDTH_DEF,
  localparam int unsigned IDX_W    = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  bjq_pkg::bjq_chain_ctrl_t ctrl_i,
  input  logic [IDX_W-1:0]        wr_idx_i,
  input  logic [JOB_WIDTH-1:0]    wr_data_i,
  output logic [JOB_WIDTH-1:0]    head_o
);

  logic [JOB_WIDTH-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [JOB_WIDTH-1:0] nbr;
    logic                 sel;

    if (i == DEPTH - 1) begin : g_top
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    assign sel = ctrl_i.wr_en && (wr_idx_i == IDX_W'(i));

    bjq_cell #(
      .JOB_WIDTH(JOB_WIDTH)
    ) u_cell (
      .clk_i     (clk_i),
      .shift_i   (ctrl_i.shift),
      .wr_i      (sel),
      .wr_data_i (wr_data_i),
      .nbr_data_i(nbr),
      .data_o    (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

@@ design/bounded_job_queue_drop_policy.sv @@
// ----------------------------------------------------------------------------
// bounded_job_queue_drop_policy
// A result is registered the cycle after its request transaction. Throughput:
// one request per cycle while results are taken and no cancel run is active.
// A cancel of N queued jobs gives N results, one per cycle while results are
// taken, and holds off new requests while the cell row shifts them out of
// the head cell. Reset clears counts, closed flag, capacity (16) and policy
// (block); job cells are not cleared, the job count alone marks those in use.
// ----------------------------------------------------------------------------
module bounded_job_queue_drop_policy #(
  parameter int unsigned DEPTH        = bjq_pkg::DEPTH_DEF,
  parameter int unsigned JOB_WIDTH    = bjq_pkg::JOB_WIDTH_DEF,
  parameter int unsigned ACTIVE_WIDTH = bjq_pkg::ACTIVE_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [bjq_pkg::CFG_A_W-1:0]  cfg_addr_i,
  input  logic [bjq_pkg::CFG_W-1:0]    cfg_data_i,
  // request channel
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  bjq_pkg::bjq_req_t            in_req_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output bjq_pkg::bjq_rsp_t            out_rsp_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]             count_q,  count_d;
  logic [ACTIVE_WIDTH-1:0]      active_q, active_d;
  logic                         closed_q, closed_d;
  logic                         cancel_q, cancel_d;   // cancel run in progress
  logic                         out_valid_q, out_valid_d;
  bjq_pkg::bjq_rsp_t            out_q, out_d;
  logic [bjq_pkg::CAP_W-1:0]    cap_q;
  logic [bjq_pkg::POL_W-1:0]    policy_q;

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  bjq_pkg::bjq_chain_ctrl_t     chain_ctrl;
  logic [IDX_W-1:0]             wr_idx;
  logic [JOB_WIDTH-1:0]         head_job;

  bjq_chain #(
    .DEPTH    (DEPTH),
    .JOB_WIDTH(JOB_WIDTH)
  ) u_chain (
    .clk_i    (clk_i),
    .ctrl_i   (chain_ctrl),
    .wr_idx_i (wr_idx),
    .wr_data_i(in_req_i.job_data[JOB_WIDTH-1:0]),
    .head_o   (head_job)
  );

  // --------------------------------------------------------------------------
  // Fullness: effective capacity is the register clamped to [1, DEPTH]
  // --------------------------------------------------------------------------
  logic [7:0] cap8, depth8, eff_cap8, count8;
  logic       full;
  logic [CNT_W-1:0] count_m1;

  assign cap8     = {3'b000, cap_q};
  assign depth8   = 8'(DEPTH);
  assign eff_cap8 = (cap8 == 8'd0) ? 8'd1 : ((cap8 > depth8) ? depth8 : cap8);
  assign count8   = {{(8 - CNT_W){1'b0}}, count_q};
  assign full     = (count8 >= eff_cap8);
  assign count_m1 = count_q - 1'b1;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic out_free, in_acc, cancel_step;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = !cancel_q && out_free;
  assign in_acc      = in_valid_i && in_ready_o;
  assign cancel_step = cancel_q && out_free;

  // --------------------------------------------------------------------------
  // Request decode and state update
  // --------------------------------------------------------------------------
  logic [bjq_pkg::STATUS_W-1:0] res_status;
  logic [JOB_WIDTH-1:0]         res_job;
  logic                         res_last;
  logic                         res_load;

  always_comb begin
    count_d          = count_q;
    active_d         = active_q;
    closed_d         = closed_q;
    cancel_d         = cancel_q;
    chain_ctrl.shift = 1'b0;
    chain_ctrl.wr_en = 1'b0;
    wr_idx           = count_q[IDX_W-1:0];
    res_status       = bjq_pkg::ST_OK;
    res_job          = '0;
    res_last         = 1'b1;
    res_load         = 1'b0;

    if (cancel_step) begin
      // next pending job of a cancel run leaves through the head cell
      res_load         = 1'b1;
      chain_ctrl.shift = 1'b1;
      res_job          = head_job;
      res_status       = bjq_pkg::ST_CANCELLED;
      count_d          = count_m1;
      res_last         = (count_q == CNT_W'(1));
      cancel_d         = (count_q != CNT_W'(1));
    end else if (in_acc) begin
      res_load = 1'b1;
      case (in_req_i.req_type)
        bjq_pkg::REQ_PUSH: begin
          if (closed_q) begin
            res_status = bjq_pkg::ST_PUSH_CLOSED;
          end else if (!full) begin
            chain_ctrl.wr_en = 1'b1;
            count_d          = count_q + 1'b1;
          end else if (policy_q == bjq_pkg::POL_DROP_NEWEST) begin
            res_status = bjq_pkg::ST_REJECTED;
          end else if (policy_q == bjq_pkg::POL_DROP_OLDEST) begin
            // evict head and append in the same cycle; count holds
            res_status       = bjq_pkg::ST_DROP_OLDEST;
            res_job          = head_job;
            chain_ctrl.shift = 1'b1;
            chain_ctrl.wr_en = 1'b1;
            wr_idx           = count_m1[IDX_W-1:0];
          end else begin
            res_status = bjq_pkg::ST_FULL_RETRY;
          end
        end
        bjq_pkg::REQ_POP: begin
          if (count_q == '0) begin
            res_status = closed_q ? bjq_pkg::ST_CLOSED : bjq_pkg::ST_EMPTY_RETRY;
          end else begin
            chain_ctrl.shift = 1'b1;
            res_job          = head_job;
            count_d          = count_m1;
            if (active_q != '1) begin
              active_d = active_q + 1'b1;
            end
          end
        end
        bjq_pkg::REQ_DONE: begin
          if (active_q != '0) begin
            active_d = active_q - 1'b1;
          end
        end
        bjq_pkg::REQ_CLOSE: begin
          closed_d = 1'b1;
        end
        bjq_pkg::REQ_CANCEL: begin
          closed_d = 1'b1;
          if (count_q == '0) begin
            res_status = bjq_pkg::ST_NOTHING;
          end else begin
            chain_ctrl.shift = 1'b1;
            res_job          = head_job;
            res_status       = bjq_pkg::ST_CANCELLED;
            count_d          = count_m1;
            res_last         = (count_q == CNT_W'(1));
            cancel_d         = (count_q != CNT_W'(1));
          end
        end
        default: begin
          // unknown request: plain ok, nothing changes
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result assembly (fields reflect state after this transaction)
  // --------------------------------------------------------------------------
  logic [64:0] job_ext;
  logic [32:0] active_ext;
  logic [7:0]  count_ext;

  assign job_ext    = {{(65 - JOB_WIDTH){1'b0}}, res_job};
  assign active_ext = {{(33 - ACTIVE_WIDTH){1'b0}}, active_d};
  assign count_ext  = {{(8 - CNT_W){1'b0}}, count_d};

  always_comb begin
    out_d              = out_q;
    out_valid_d        = out_valid_q;
    if (res_load) begin
      out_valid_d        = 1'b1;
      out_d.status       = res_status;
      out_d.job_out      = job_ext[bjq_pkg::JOB_W-1:0];
      out_d.last         = res_last;
      out_d.queue_count  = count_ext[bjq_pkg::QCNT_W-1:0];
      out_d.active_count = active_ext[bjq_pkg::ACNT_W-1:0];
      out_d.drained      = (count_d == '0) && (active_d == '0);
      out_d.is_closed    = closed_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      active_q    <= '0;
      closed_q    <= 1'b0;
      cancel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      active_q    <= active_d;
      closed_q    <= closed_d;
      cancel_q    <= cancel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // User makes configuration writes only while idle; no interlock enforces it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= bjq_pkg::CAP_RESET;
      policy_q <= bjq_pkg::POL_BLOCK;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        bjq_pkg::CFG_CAPACITY: cap_q    <= cfg_data_i[bjq_pkg::CAP_W-1:0];
        bjq_pkg::CFG_POLICY:   policy_q <= cfg_data_i[bjq_pkg::POL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule
